[hdl/fifo_with_priority_insert_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the priority insert queue
// Shared property forms; every use expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_PRIORITY_INSERT_DEFINES_SVH
`define FIFO_WITH_PRIORITY_INSERT_DEFINES_SVH

// same-cycle implication
`define FPI_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/fpi_pkg.sv]
// ----------------------------------------------------------------------------
// fpi_pkg
// Command and status codes and the control group fed to every queue cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpi_pkg;

  localparam logic [1:0] CMD_PUSH_TAIL = 2'd0;
  localparam logic [1:0] CMD_PUSH_SORT = 2'd1;
  localparam logic [1:0] CMD_POP       = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // broadcast to the cell row, already gated by full / empty
  typedef struct packed {
    logic push_tail;
    logic push_sort;
    logic pop;
  } fpi_ctrl_t;

endpackage

`default_nettype wire

[hdl/fpi_cell.sv]
// ----------------------------------------------------------------------------
// fpi_cell
// One queue slot. Holds, loads the new item, or takes its left or right
// neighbor's entry, depending on the broadcast command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpi_cell
  import fpi_pkg::*;
#(
  parameter int PRIORITY_WIDTH = 8,
  parameter int PAYLOAD_WIDTH  = 32
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire fpi_ctrl_t           ctrl,
  input  wire [PRIORITY_WIDTH-1:0] item_pri,
  input  wire [PAYLOAD_WIDTH-1:0]  item_pay,
  input  wire                      left_valid,
  input  wire [PRIORITY_WIDTH-1:0] left_pri,
  input  wire [PAYLOAD_WIDTH-1:0]  left_pay,
  input  wire                      right_valid,
  input  wire [PRIORITY_WIDTH-1:0] right_pri,
  input  wire [PAYLOAD_WIDTH-1:0]  right_pay,
  input  wire                      found_in,
  output logic                     found_out,
  output logic                     valid,
  output logic [PRIORITY_WIDTH-1:0] pri,
  output logic [PAYLOAD_WIDTH-1:0]  pay,
  output logic                     valid_next,
  output logic [PRIORITY_WIDTH-1:0] pri_next,
  output logic [PAYLOAD_WIDTH-1:0]  pay_next
);

  logic gt;

  assign gt        = ctrl.push_sort && valid && (pri > item_pri);
  assign found_out = found_in || gt;

  always_comb begin
    valid_next = valid;
    pri_next   = pri;
    pay_next   = pay;
    if (ctrl.pop) begin
      valid_next = right_valid;
      pri_next   = right_pri;
      pay_next   = right_pay;
    end else if (ctrl.push_tail) begin
      if (!valid && left_valid) begin
        valid_next = 1'b1;
        pri_next   = item_pri;
        pay_next   = item_pay;
      end
    end else if (ctrl.push_sort) begin
      if (found_in) begin
        // insertion point lies to the left: shift right by one
        valid_next = left_valid;
        pri_next   = left_pri;
        pay_next   = left_pay;
      end else if (gt || (!valid && left_valid)) begin
        valid_next = 1'b1;
        pri_next   = item_pri;
        pay_next   = item_pay;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pri <= pri_next;
    pay <= pay_next;
  end

endmodule

`default_nettype wire

[hdl/fifo_with_priority_insert.sv]
// ----------------------------------------------------------------------------
// fifo_with_priority_insert
// Bounded queue with tail push, sorted insert and head pop.
// ----------------------------------------------------------------------------
// One command is taken per clock cycle and its result beat appears on the
// master side in the next cycle, held in a single output register; the slave
// side stalls only while that register is full and not being read. The rate
// is set by the row of DEPTH slot cells, which all update in the same cycle;
// the insert position is found by a priority-compare chain that runs along
// the row. Head is slot 0; the tail entry is tracked in a separate register.
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_priority_insert
  import fpi_pkg::*;
#(
  parameter int DEPTH          = 16,
  parameter int PRIORITY_WIDTH = 8,
  parameter int PAYLOAD_WIDTH  = 32
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  s_tvalid,
  output logic s_tready,
  // command, item_priority, item_payload, zero fill
  input  wire  [((2 + PRIORITY_WIDTH + PAYLOAD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  output logic m_tvalid,
  input  wire  m_tready,
  // popped_valid, popped_priority, popped_payload, head_priority, head_payload,
  // tail_priority, tail_payload, entry_count, status, zero fill
  output logic [((3 * (PRIORITY_WIDTH + PAYLOAD_WIDTH) + $clog2(DEPTH + 1) + 3 + 7)
                 / 8) * 8 - 1:0] m_tdata
);

  localparam int PW  = PRIORITY_WIDTH;
  localparam int YW  = PAYLOAD_WIDTH;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int OUT_BITS = 3 * (PW + YW) + CW + 3;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  logic [1:0]    command;
  logic [PW-1:0] item_pri;
  logic [YW-1:0] item_pay;
  logic          accept;
  logic          full;
  logic          empty;
  fpi_ctrl_t     ctrl;
  logic [1:0]    status;

  logic          cell_valid      [DEPTH];
  logic [PW-1:0] cell_pri        [DEPTH];
  logic [YW-1:0] cell_pay        [DEPTH];
  logic          cell_valid_next [DEPTH];
  logic [PW-1:0] cell_pri_next   [DEPTH];
  logic [YW-1:0] cell_pay_next   [DEPTH];
  logic          found           [DEPTH+1];

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [PW-1:0] tail_pri;
  logic [YW-1:0] tail_pay;
  logic [PW-1:0] tail_pri_next;
  logic [YW-1:0] tail_pay_next;

  logic          pop_valid;
  logic [PW-1:0] pop_pri;
  logic [YW-1:0] pop_pay;
  logic [PW-1:0] head_pri_out;
  logic [YW-1:0] head_pay_out;
  logic [PW-1:0] tail_pri_out;
  logic [YW-1:0] tail_pay_out;

  assign command  = s_tdata[1:0];
  assign item_pri = s_tdata[2 +: PW];
  assign item_pay = s_tdata[2 + PW +: YW];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign full  = cell_valid[DEPTH-1];
  assign empty = !cell_valid[0];

  always_comb begin
    ctrl   = '0;
    status = ST_OK;
    if (accept) begin
      unique case (command)
        CMD_PUSH_TAIL: begin
          if (full) status = ST_FULL;
          else      ctrl.push_tail = 1'b1;
        end
        CMD_PUSH_SORT: begin
          if (full) status = ST_FULL;
          else      ctrl.push_sort = 1'b1;
        end
        CMD_POP: begin
          if (empty) status = ST_EMPTY;
          else       ctrl.pop = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign found[0] = 1'b0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic          lv;
    logic [PW-1:0] lp;
    logic [YW-1:0] ld;
    logic          rv;
    logic [PW-1:0] rp;
    logic [YW-1:0] rd;

    if (k == 0) begin : g_left_end
      assign lv = 1'b1;
      assign lp = '0;
      assign ld = '0;
    end else begin : g_left
      assign lv = cell_valid[k-1];
      assign lp = cell_pri[k-1];
      assign ld = cell_pay[k-1];
    end

    if (k == DEPTH - 1) begin : g_right_end
      assign rv = 1'b0;
      assign rp = '0;
      assign rd = '0;
    end else begin : g_right
      assign rv = cell_valid[k+1];
      assign rp = cell_pri[k+1];
      assign rd = cell_pay[k+1];
    end

    fpi_cell #(
      .PRIORITY_WIDTH (PW),
      .PAYLOAD_WIDTH  (YW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .item_pri    (item_pri),
      .item_pay    (item_pay),
      .left_valid  (lv),
      .left_pri    (lp),
      .left_pay    (ld),
      .right_valid (rv),
      .right_pri   (rp),
      .right_pay   (rd),
      .found_in    (found[k]),
      .found_out   (found[k+1]),
      .valid       (cell_valid[k]),
      .pri         (cell_pri[k]),
      .pay         (cell_pay[k]),
      .valid_next  (cell_valid_next[k]),
      .pri_next    (cell_pri_next[k]),
      .pay_next    (cell_pay_next[k])
    );
  end

  always_comb begin
    count_next    = count;
    tail_pri_next = tail_pri;
    tail_pay_next = tail_pay;
    if (ctrl.push_tail || ctrl.push_sort) begin
      count_next = count + CW'(1);
      // sorted insert lands at the tail only when nothing stored is greater
      if (ctrl.push_tail || !found[DEPTH]) begin
        tail_pri_next = item_pri;
        tail_pay_next = item_pay;
      end
    end else if (ctrl.pop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    tail_pri <= tail_pri_next;
    tail_pay <= tail_pay_next;
  end

  assign pop_valid    = ctrl.pop;
  assign pop_pri      = ctrl.pop ? cell_pri[0] : '0;
  assign pop_pay      = ctrl.pop ? cell_pay[0] : '0;
  assign head_pri_out = cell_valid_next[0] ? cell_pri_next[0] : '0;
  assign head_pay_out = cell_valid_next[0] ? cell_pay_next[0] : '0;
  assign tail_pri_out = cell_valid_next[0] ? tail_pri_next : '0;
  assign tail_pay_out = cell_valid_next[0] ? tail_pay_next : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= OUT_W'({status, count_next, tail_pay_out, tail_pri_out,
                         head_pay_out, head_pri_out, pop_pay, pop_pri, pop_valid});
    end
  end

endmodule

`default_nettype wire

[hdl/fifo_with_priority_insert_checker.sv]
// ----------------------------------------------------------------------------
// fifo_with_priority_insert_checker
// Port-level checks on result beats of the priority insert queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fifo_with_priority_insert_defines.svh"

module fifo_with_priority_insert_checker
  import fpi_pkg::*;
#(
  parameter int DEPTH          = 16,
  parameter int PRIORITY_WIDTH = 8,
  parameter int PAYLOAD_WIDTH  = 32
) (
  input wire clk,
  input wire rst,
  input wire m_tvalid,
  input wire m_tready,
  input wire [((3 * (PRIORITY_WIDTH + PAYLOAD_WIDTH) + $clog2(DEPTH + 1) + 3 + 7)
               / 8) * 8 - 1:0] m_tdata
);

  localparam int PW = PRIORITY_WIDTH;
  localparam int YW = PAYLOAD_WIDTH;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int O_PP = 1;
  localparam int O_PD = O_PP + PW;
  localparam int O_HP = O_PD + YW;
  localparam int O_HD = O_HP + PW;
  localparam int O_TP = O_HD + YW;
  localparam int O_TD = O_TP + PW;
  localparam int O_CN = O_TD + YW;
  localparam int O_ST = O_CN + CW;

  logic          pv;
  logic [PW-1:0] ppri;
  logic [YW-1:0] ppay;
  logic [PW-1:0] hpri;
  logic [YW-1:0] hpay;
  logic [PW-1:0] tpri;
  logic [YW-1:0] tpay;
  logic [CW-1:0] cnt;
  logic [1:0]    st;

  assign pv   = m_tdata[0];
  assign ppri = m_tdata[O_PP +: PW];
  assign ppay = m_tdata[O_PD +: YW];
  assign hpri = m_tdata[O_HP +: PW];
  assign hpay = m_tdata[O_HD +: YW];
  assign tpri = m_tdata[O_TP +: PW];
  assign tpay = m_tdata[O_TD +: YW];
  assign cnt  = m_tdata[O_CN +: CW];
  assign st   = m_tdata[O_ST +: 2];

  `FPI_ASSERT_NEXT(a_beat_held, m_tvalid && !m_tready, m_tvalid, "result beat dropped")
  `FPI_ASSERT_IMPLY(a_count_range, m_tvalid, cnt <= CW'(DEPTH), "count beyond depth")
  `FPI_ASSERT_IMPLY(a_full_drop, m_tvalid && st == ST_FULL, cnt == CW'(DEPTH) && !pv, "bad full drop")
  `FPI_ASSERT_IMPLY(a_empty_pop, m_tvalid && st == ST_EMPTY, cnt == '0 && !pv && ppri == '0 && ppay == '0, "bad empty pop")
  `FPI_ASSERT_IMPLY(a_empty_view, m_tvalid && cnt == '0, hpri == '0 && hpay == '0 && tpri == '0 && tpay == '0, "empty queue shows entries")

endmodule

bind fifo_with_priority_insert fifo_with_priority_insert_checker #(
  .DEPTH          (DEPTH),
  .PRIORITY_WIDTH (PRIORITY_WIDTH),
  .PAYLOAD_WIDTH  (PAYLOAD_WIDTH)
) u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/fifo_with_priority_insert_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_priority_insert_scoreboard
// Watches both streams of the priority insert queue. It keeps its own copy of
// the queue to predict every result beat and compares each field in order.
// ----------------------------------------------------------------------------

module fifo_with_priority_insert_scoreboard
  import fpi_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  input  wire          s_tready,
  input  wire  [47:0]  s_tdata,
  input  wire          m_tvalid,
  input  wire          m_tready,
  input  wire  [127:0] m_tdata,
  output int           mismatches,
  output int           pending,
  output int           results_checked,
  output int           full_refusals,
  output int           empty_pops
);

  // packed structs list the fields from the top bit down
  typedef struct packed {
    logic [5:0]  fill;
    logic [31:0] payload;
    logic [7:0]  prio;
    logic [1:0]  command;
  } cmd_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic [31:0] tail_payload;
    logic [7:0]  tail_prio;
    logic [31:0] head_payload;
    logic [7:0]  head_prio;
    logic [31:0] popped_payload;
    logic [7:0]  popped_prio;
    logic        popped_valid;
  } result_beat_t;

  typedef struct packed {
    logic [7:0]  prio;
    logic [31:0] payload;
  } queue_entry_t;

  queue_entry_t stored[$];
  result_beat_t expected_results[$];

  initial begin
    mismatches      = 0;
    pending         = 0;
    results_checked = 0;
    full_refusals   = 0;
    empty_pops      = 0;
  end

  function automatic result_beat_t apply_command(input cmd_beat_t b);
    result_beat_t r;
    queue_entry_t e;
    int           pos;
    r = '0;
    r.status = ST_OK;
    case (b.command)
      CMD_PUSH_TAIL, CMD_PUSH_SORT: begin
        if (stored.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = stored.size();
          // first entry with a strictly greater priority; ties stay in arrival order
          if (b.command == CMD_PUSH_SORT)
            for (int k = stored.size() - 1; k >= 0; k--)
              if (stored[k].prio > b.prio) pos = k;
          e.prio    = b.prio;
          e.payload = b.payload;
          stored.insert(pos, e);
        end
      end
      CMD_POP: begin
        if (stored.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          e = stored.pop_front();
          r.popped_valid   = 1'b1;
          r.popped_prio    = e.prio;
          r.popped_payload = e.payload;
        end
      end
      default: ;
    endcase
    if (stored.size() > 0) begin
      r.head_prio    = stored[0].prio;
      r.head_payload = stored[0].payload;
      r.tail_prio    = stored[stored.size() - 1].prio;
      r.tail_payload = stored[stored.size() - 1].payload;
    end
    r.entry_count = 5'(stored.size());
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_beat_t want;
    result_beat_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        want = apply_command(cmd_beat_t'(s_tdata));
        if (want.status == ST_FULL) full_refusals++;
        if (want.status == ST_EMPTY) empty_pops++;
        expected_results.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = result_beat_t'(m_tdata);
        if (expected_results.size() == 0) begin
          $error("result beat with no command pending: 0x%0h", m_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          check_field("popped_valid", want.popped_valid, got.popped_valid);
          check_field("popped_priority", want.popped_prio, got.popped_prio);
          check_field("popped_payload", want.popped_payload, got.popped_payload);
          check_field("head_priority", want.head_prio, got.head_prio);
          check_field("head_payload", want.head_payload, got.head_payload);
          check_field("tail_priority", want.tail_prio, got.tail_prio);
          check_field("tail_payload", want.tail_payload, got.tail_payload);
          check_field("entry_count", want.entry_count, got.entry_count);
          check_field("status", want.status, got.status);
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives tail pushes, sorted inserts, pops and no-ops into the priority
// insert queue with random gaps and back-pressure; the checker does the rest.
// ----------------------------------------------------------------------------

module testbench
  import fpi_pkg::*;
;

  localparam int         QUEUE_DEPTH = 16;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         LONG_HOLD   = 80;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  wire           s_tready;
  logic [47:0]   s_tdata = '0;   // command, item_priority, item_payload, zero fill
  wire           m_tvalid;
  logic          m_tready = 1'b0;
  wire  [127:0]  m_tdata;        // popped_valid .. status, see checker

  int mismatches;
  int pending;
  int results_checked;
  int full_refusals;
  int empty_pops;
  int cycle_count = 0;

  logic sender_idle_on = 1'b1;
  logic sink_idle_on   = 1'b1;
  logic long_hold_req  = 1'b0;

  always #2 clk = ~clk;

  fifo_with_priority_insert #(
    .DEPTH          (QUEUE_DEPTH),
    .PRIORITY_WIDTH (8),
    .PAYLOAD_WIDTH  (32)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  fifo_with_priority_insert_scoreboard #(
    .DEPTH (QUEUE_DEPTH)
  ) fpi_check (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .full_refusals   (full_refusals),
    .empty_pops      (empty_pops)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        m_tready <= !(sink_idle_on && $urandom_range(99) < 12);
        @(posedge clk);
      end
    end
  end

  // valid stays high from one beat to the next unless a gap is drawn
  task automatic send_beat(input logic [1:0] cmd, input logic [7:0] prio,
                           input logic [31:0] payload);
    while (sender_idle_on && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, payload, prio, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random(input int push_pct);
    logic [1:0]  cmd;
    logic [7:0]  prio;
    logic [31:0] payload;
    int          roll;
    roll = $urandom_range(99);
    if (roll < 3)
      cmd = CMD_NOP;
    else if (roll < push_pct)
      cmd = ($urandom_range(2) != 0) ? CMD_PUSH_SORT : CMD_PUSH_TAIL;
    else
      cmd = CMD_POP;
    // narrow priority sets make ties common
    case ($urandom_range(3))
      0:       prio = 8'($urandom_range(3));
      1:       prio = 8'(255 - $urandom_range(3));
      default: prio = 8'($urandom);
    endcase
    payload = $urandom;
    send_beat(cmd, prio, payload);
  endtask

  initial begin
    int push_pct;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty pop, no-op, extremes, ties, fill to full, refused pushes
    send_beat(CMD_POP, 8'hFF, 32'hFFFF_FFFF);
    send_beat(CMD_NOP, 8'h00, 32'h0000_0000);
    send_beat(CMD_PUSH_TAIL, 8'hFF, 32'hFFFF_FFFF);
    send_beat(CMD_PUSH_SORT, 8'h00, 32'h0000_0000);
    send_beat(CMD_PUSH_SORT, 8'h80, 32'hA5A5_0001);
    send_beat(CMD_PUSH_SORT, 8'h80, 32'hA5A5_0002);
    send_beat(CMD_PUSH_TAIL, 8'h07, 32'h5A5A_5A5A);
    for (int i = 0; i < 11; i++)
      send_beat(CMD_PUSH_SORT, 8'(i * 23), 32'h1000_0000 + i);
    send_beat(CMD_PUSH_TAIL, 8'h01, 32'hDEAD_0001);
    send_beat(CMD_PUSH_SORT, 8'h01, 32'hDEAD_0002);
    send_beat(CMD_POP, 8'h00, 32'h0000_0000);

    // random blocks each draw a push share that leans to draining, mixing or filling the queue
    for (int blk = 0; blk < 20; blk++) begin
      case ($urandom_range(2))
        0:       push_pct = 25;
        1:       push_pct = 55;
        default: push_pct = 85;
      endcase
      sender_idle_on = !(blk >= 8 && blk <= 10);
      sink_idle_on   = sender_idle_on;
      for (int i = 0; i < 50; i++) send_random(push_pct);
    end

    // back-pressure: result side holds off while commands keep coming
    sender_idle_on = 1'b0;
    long_hold_req  = 1'b1;
    for (int i = 0; i < 40; i++) send_random(60);
    sender_idle_on = 1'b1;
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("checked %0d result beats from tail pushes, sorted inserts, pops and no-ops",
             results_checked);
    $display("full-queue pushes refused: %0d, pops on empty queue: %0d",
             full_refusals, empty_pops);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/fpi_pkg.sv
hdl/fpi_cell.sv
hdl/fifo_with_priority_insert.sv
hdl/fifo_with_priority_insert_checker.sv
tb/fifo_with_priority_insert_checker.sv
tb/testbench.sv
